[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the control law unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while arst_n is low.
`define CHECK_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Same-cycle implication checked on every rising clk edge.
`define CHECK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

[rtl/cdcl_pkg.sv]
// Package: widths, lane codes and types of the critically damped control law unit.
package cdcl_pkg;

	// Default derivative order (2 or 3).
	localparam int ORDER_DEF = 3;

	// Front-end arithmetic widths.
	localparam int MW = 66;   // first-stage products
	localparam int HW = 67;   // split partial products
	localparam int PW = 99;   // recombined split products
	localparam int DW = 103;  // signed denominator
	localparam int NW = 120;  // signed numerator

	// Divider: quotient bits (32 result, 1 guard, 1 rounding) and compare width.
	localparam int QB = 34;
	localparam int CW = 136;

	// Split-multiplier lanes.
	localparam int LANES = 7;
	localparam int L_TTT = 0;  // T^2 * T
	localparam int L_QQQ = 1;  // qo^2 * qo
	localparam int L_TDD = 2;  // d^2 * T
	localparam int L_TTD = 3;  // T^2 * d
	localparam int L_TTX = 4;  // T^2 * x2
	localparam int L_QQX = 5;  // qo^2 * x2
	localparam int L_TDX = 6;  // T*d * x2

	// Clamp bounds of the magnitude.
	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

	// Flags that travel with an item through the divider.
	typedef struct packed {
		logic neg;
		logic ovf;
		logic bad;
	} div_meta_t;

endpackage

[rtl/critically_damped_control_law_unit.sv]
// Top level: pipelined critically damped control law, one component per transfer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  item     | item_valid / item_ready   | timescale, error_value, first_derivative,
//           |                           | second_derivative, value_time_offset,
//           |                           | derivative_time_offset
//  result   | result_valid/result_ready | control_value, saturated
//
// One item enters per cycle while the output is not held; a result passes through
// 8 arithmetic stages, divider entry, 34 restoring-division stages and the output register.
// The restoring divider forms a 34-step quotient.
// Reset clears only the valid bits; payload registers are not reset.
// When the output register is full and not taken, the whole pipeline holds.

`include "assert_macros.svh"

module critically_damped_control_law_unit #(
	parameter int DERIV_ORDER = cdcl_pkg::ORDER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [31:0]        timescale,
	input  logic signed [31:0] error_value,
	input  logic signed [31:0] first_derivative,
	input  logic signed [31:0] second_derivative,
	input  logic signed [31:0] value_time_offset,
	input  logic signed [31:0] derivative_time_offset,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] control_value,
	output logic               saturated
);
	import cdcl_pkg::*;

	// Pipeline advance: whole pipe moves unless the output is held.
	logic adv;
	logic out_vld_q;
	assign adv        = !out_vld_q || result_ready;
	assign item_ready = adv;

	// ---------------- stage 1: 32x32 products ----------------
	logic               vld_s1, tz_s1;
	logic signed [32:0] ts_s1;
	logic signed [31:0] qo_s1, d_s1, x0_s1, x2_s1;
	logic signed [MW-1:0] tt_s1, qq_s1, td_s1, dd_s1, tx1_s1, qx1_s1;
	logic signed [32:0] ts_c;

	assign ts_c = $signed({1'b0, timescale});

	always_ff @(posedge clk) begin
		if (adv) begin
			tz_s1  <= (timescale == 32'd0);
			ts_s1  <= ts_c;
			qo_s1  <= value_time_offset;
			d_s1   <= derivative_time_offset;
			x0_s1  <= error_value;
			x2_s1  <= second_derivative;
			tt_s1  <= MW'(ts_c) * MW'(ts_c);
			qq_s1  <= MW'(value_time_offset) * MW'(value_time_offset);
			td_s1  <= MW'(ts_c) * MW'(derivative_time_offset);
			dd_s1  <= MW'(derivative_time_offset) * MW'(derivative_time_offset);
			tx1_s1 <= MW'(ts_c) * MW'(first_derivative);
			qx1_s1 <= MW'(value_time_offset) * MW'(first_derivative);
		end
	end

	// ---------------- stage 2: split wide-by-32 products ----------------
	logic signed [MW-1:0] la [LANES];
	logic signed [32:0]   lb [LANES];

	// Lane operands
	always_comb begin
		la[L_TTT] = tt_s1;  lb[L_TTT] = ts_s1;
		la[L_QQQ] = qq_s1;  lb[L_QQQ] = 33'(qo_s1);
		la[L_TDD] = dd_s1;  lb[L_TDD] = ts_s1;
		la[L_TTD] = tt_s1;  lb[L_TTD] = 33'(d_s1);
		la[L_TTX] = tt_s1;  lb[L_TTX] = 33'(x2_s1);
		la[L_QQX] = qq_s1;  lb[L_QQX] = 33'(x2_s1);
		la[L_TDX] = td_s1;  lb[L_TDX] = 33'(x2_s1);
	end

	logic                 vld_s2, tz_s2;
	logic signed [HW-1:0] ph_s2 [LANES];
	logic signed [HW-1:0] pl_s2 [LANES];
	logic signed [31:0]   x0_s2;
	logic signed [MW-1:0] tt_s2, qq_s2, td_s2, tx1_s2, qx1_s2;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic signed [MW-33:0] hi;
		logic signed [32:0]    lo;
		assign hi = $signed(la[k][MW-1:32]);
		assign lo = $signed({1'b0, la[k][31:0]});
		always_ff @(posedge clk) begin
			if (adv) begin
				ph_s2[k] <= HW'(hi) * HW'(lb[k]);
				pl_s2[k] <= HW'(lo) * HW'(lb[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tz_s2  <= tz_s1;
			x0_s2  <= x0_s1;
			tt_s2  <= tt_s1;
			qq_s2  <= qq_s1;
			td_s2  <= td_s1;
			tx1_s2 <= tx1_s1;
			qx1_s2 <= qx1_s1;
		end
	end

	// ---------------- stage 3: recombine partial products ----------------
	logic                 vld_s3, tz_s3;
	logic signed [PW-1:0] p_s3 [LANES];
	logic signed [31:0]   x0_s3;
	logic signed [MW-1:0] tt_s3, qq_s3, td_s3, tx1_s3, qx1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++)
				p_s3[k] <= (PW'(ph_s2[k]) <<< 32) + PW'(pl_s2[k]);
			tz_s3  <= tz_s2;
			x0_s3  <= x0_s2;
			tt_s3  <= tt_s2;
			qq_s3  <= qq_s2;
			td_s3  <= td_s2;
			tx1_s3 <= tx1_s2;
			qx1_s3 <= qx1_s2;
		end
	end

	// ---------------- stage 4: constant gains and alignment ----------------
	logic signed [DW-1:0] den_c [4];
	logic signed [NW-1:0] num_c [6];

	always_comb begin
		if (DERIV_ORDER == 3) begin
			// D*6T^3 form: 6T^3 + qo^3 + 9Td^2 + 18T^2d
			den_c[0] = (DW'(p_s3[L_TTT]) <<< 2) + (DW'(p_s3[L_TTT]) <<< 1);
			den_c[1] = DW'(p_s3[L_QQQ]);
			den_c[2] = (DW'(p_s3[L_TDD]) <<< 3) + DW'(p_s3[L_TDD]);
			den_c[3] = (DW'(p_s3[L_TTD]) <<< 4) + (DW'(p_s3[L_TTD]) <<< 1);
			// 6x0, (18T + 6qo)x1, (18T^2 + 3qo^2 + 18Td)x2, Q16.16 aligned
			num_c[0] = (NW'(x0_s3) <<< 50) + (NW'(x0_s3) <<< 49);
			num_c[1] = (NW'(tx1_s3) <<< 36) + (NW'(tx1_s3) <<< 33);
			num_c[2] = (NW'(qx1_s3) <<< 34) + (NW'(qx1_s3) <<< 33);
			num_c[3] = (NW'(p_s3[L_TTX]) <<< 20) + (NW'(p_s3[L_TTX]) <<< 17);
			num_c[4] = (NW'(p_s3[L_QQX]) <<< 17) + (NW'(p_s3[L_QQX]) <<< 16);
			num_c[5] = (NW'(p_s3[L_TDX]) <<< 20) + (NW'(p_s3[L_TDX]) <<< 17);
		end else begin
			// D*2T^2 form: 2T^2 + qo^2 + 4Td
			den_c[0] = DW'(tt_s3) <<< 1;
			den_c[1] = DW'(qq_s3);
			den_c[2] = DW'(td_s3) <<< 2;
			den_c[3] = '0;
			// 2x0, (4T + 2qo)x1
			num_c[0] = NW'(x0_s3) <<< 33;
			num_c[1] = NW'(tx1_s3) <<< 18;
			num_c[2] = NW'(qx1_s3) <<< 17;
			num_c[3] = '0;
			num_c[4] = '0;
			num_c[5] = '0;
		end
	end

	logic                 vld_s4, tz_s4;
	logic signed [DW-1:0] den_s4 [4];
	logic signed [NW-1:0] num_s4 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4 <= den_c;
			num_s4 <= num_c;
			tz_s4  <= tz_s3;
		end
	end

	// ---------------- stages 5..7: adder tree ----------------
	logic                 vld_s5, tz_s5, vld_s6, tz_s6, vld_s7, tz_s7;
	logic signed [DW-1:0] dsum_s5 [2];
	logic signed [NW-1:0] nsum_s5 [3];
	logic signed [DW-1:0] den_s6, den_s7;
	logic signed [NW-1:0] npart_s6, nlast_s6, num_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			dsum_s5[0] <= den_s4[0] + den_s4[1];
			dsum_s5[1] <= den_s4[2] + den_s4[3];
			nsum_s5[0] <= num_s4[0] + num_s4[1];
			nsum_s5[1] <= num_s4[2] + num_s4[3];
			nsum_s5[2] <= num_s4[4] + num_s4[5];
			tz_s5      <= tz_s4;
			den_s6     <= dsum_s5[0] + dsum_s5[1];
			npart_s6   <= nsum_s5[0] + nsum_s5[1];
			nlast_s6   <= nsum_s5[2];
			tz_s6      <= tz_s5;
			num_s7     <= npart_s6 + nlast_s6;
			den_s7     <= den_s6;
			tz_s7      <= tz_s6;
		end
	end

	// ---------------- stage 8: sign, magnitude, special cases ----------------
	logic            vld_s8, neg_s8, bad_s8;
	logic [NW-1:0]   mag_s8;
	logic [DW-2:0]   den_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s8 <= num_s7[NW-1];
			mag_s8 <= num_s7[NW-1] ? NW'(-num_s7) : NW'(num_s7);
			bad_s8 <= tz_s7 || den_s7[DW-1] || (den_s7 == '0);
			den_s8 <= den_s7[DW-2:0];
		end
	end

	// ---------------- divider: entry (index 0) and one bit per stage ----------------
	// Dividend is 2*|num|, so the quotient carries one rounding bit.
	logic [QB:0]    div_vld_s9;
	logic [CW-1:0]  div_rem_s9  [QB+1];
	logic [DW-2:0]  div_den_s9  [QB+1];
	logic [QB-1:0]  div_quo_s9  [QB+1];
	div_meta_t      div_meta_s9 [QB+1];
	logic [CW-1:0]  dividend;

	assign dividend = CW'({mag_s8, 1'b0});

	always_ff @(posedge clk) begin
		if (adv) begin
			div_rem_s9[0]      <= dividend;
			div_den_s9[0]      <= den_s8;
			div_quo_s9[0]      <= '0;
			div_meta_s9[0].neg <= neg_s8;
			div_meta_s9[0].bad <= bad_s8;
			div_meta_s9[0].ovf <= dividend >= (CW'(den_s8) << QB);
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [CW:0] diff;
		assign diff = {1'b0, div_rem_s9[k-1]} - {1'b0, (CW'(div_den_s9[k-1]) << (QB - k))};
		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s9[k]  <= diff[CW] ? div_rem_s9[k-1] : diff[CW-1:0];
				div_quo_s9[k]  <= {div_quo_s9[k-1][QB-2:0], !diff[CW]};
				div_den_s9[k]  <= div_den_s9[k-1];
				div_meta_s9[k] <= div_meta_s9[k-1];
			end
		end
	end

	// ---------------- output: round, clamp, sign ----------------
	div_meta_t  fm;
	logic [QB:0]   rsum;
	logic [QB-1:0] rnd;
	logic [31:0]   limit, mag_v;
	logic          over;
	logic signed [31:0] cv_c;
	logic          sat_c;

	always_comb begin
		fm    = div_meta_s9[QB];
		rsum  = {1'b0, div_quo_s9[QB]} + (QB+1)'(1);
		rnd   = rsum[QB:1];
		limit = fm.neg ? NEG_LIMIT : POS_LIMIT;
		over  = fm.ovf || (rnd > QB'(limit));
		mag_v = over ? limit : rnd[31:0];
		if (fm.bad) begin
			cv_c  = '0;
			sat_c = 1'b1;
		end else begin
			cv_c  = fm.neg ? $signed(32'd0 - mag_v) : $signed(mag_v);
			sat_c = over;
		end
	end

	logic signed [31:0] cv_q;
	logic               sat_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			cv_q  <= cv_c;
			sat_q <= sat_c;
		end
	end

	assign result_valid  = out_vld_q;
	assign control_value = cv_q;
	assign saturated     = sat_q;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			vld_s8     <= 1'b0;
			div_vld_s9 <= '0;
			out_vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1     <= item_valid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			vld_s7     <= vld_s6;
			vld_s8     <= vld_s7;
			div_vld_s9 <= {div_vld_s9[QB-1:0], vld_s8};
			out_vld_q  <= div_vld_s9[QB];
		end
	end

	// ---------------- assertions ----------------
	`CHECK_CLK(a_take_lands_s1, item_valid && item_ready |=> vld_s1, "accepted item lost at stage 1")
	`CHECK_CLK(a_stall_freezes, !adv |=> $stable(div_vld_s9), "divider moved during a stall")
	`CHECK_IMPLY(a_div_entry_bound, div_vld_s9[0] && !div_meta_s9[0].bad && !div_meta_s9[0].ovf,
		div_rem_s9[0] < (CW'(div_den_s9[0]) << QB), "dividend exceeds quotient range")
	`CHECK_IMPLY(a_div_final_rem, div_vld_s9[QB] && !div_meta_s9[QB].bad && !div_meta_s9[QB].ovf,
		div_rem_s9[QB] < CW'(div_den_s9[QB]), "final remainder not below divisor")

endmodule
